// ----- rtl/ibs_pkg.sv -----
// Shared types and constants for the interval bin statistics block.
// No dependencies; used by every module under rtl/.
package ibs_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 17;
	localparam int SUM_W    = 32;
	localparam int SQSUM_W  = 48;
	localparam int WIDE_W   = 64;

	localparam logic [COUNT_W-1:0]  MAX_BINS = 17'd65536;
	localparam logic [SAMPLE_W-1:0] SMP_MAX  = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] SMP_MIN  = 16'h8000;

	// accumulator snapshot handed to the sequencer at interval end
	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [SUM_W-1:0]    sum;
		logic [SQSUM_W-1:0]  sumsq;
		logic [SAMPLE_W-1:0] min_v;
		logic [SAMPLE_W-1:0] max_v;
		logic                ovf;
	} acc_t;

	// one finished result
	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic                has_values;
		logic [SUM_W-1:0]    total;
		logic [SAMPLE_W-1:0] smallest;
		logic [SAMPLE_W-1:0] largest;
		logic [SAMPLE_W-1:0] mean;
		logic [SAMPLE_W-1:0] deviation;
		logic                has_dev;
		logic                ovf;
	} res_t;

endpackage

// ----- rtl/ibs_addsub.sv -----
// Shared 64-bit add/subtract unit with carry out (carry = no borrow on subtract).
// Depends on ibs_pkg.
module ibs_addsub (
	input  logic [ibs_pkg::WIDE_W-1:0] a,
	input  logic [ibs_pkg::WIDE_W-1:0] b,
	input  logic                       sub,
	output logic [ibs_pkg::WIDE_W-1:0] res,
	output logic                       carry
);

	logic [ibs_pkg::WIDE_W:0] full;

	always_comb begin
		full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{ibs_pkg::WIDE_W{1'b0}}, sub};
		res = full[ibs_pkg::WIDE_W-1:0];
		carry = full[ibs_pkg::WIDE_W];
	end

endmodule

// ----- rtl/ibs_accum.sv -----
// Running accumulators: count, sum, sum of squares, min, max, overflow.
// One squaring stage ahead of the accumulate. Depends on ibs_pkg.
module ibs_accum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_fire,
	input  logic signed [ibs_pkg::SAMPLE_W-1:0] sample,
	input  logic                                sample_missing,
	input  logic                                last_in_interval,
	input  logic                                clear,
	output ibs_pkg::acc_t                       acc,
	output logic                                fin,
	output logic                                pend
);

	logic                                vld_s1;
	logic                                val_s1;
	logic                                last_s1;
	logic signed [ibs_pkg::SAMPLE_W-1:0] smp_s1;
	logic [31:0]                         sqr_s1;
	logic signed [31:0]                  sqr_d;

	logic [ibs_pkg::COUNT_W-1:0]  count_q;
	logic [ibs_pkg::SUM_W-1:0]    sum_q;
	logic [ibs_pkg::SQSUM_W-1:0]  sumsq_q;
	logic [ibs_pkg::SAMPLE_W-1:0] min_q;
	logic [ibs_pkg::SAMPLE_W-1:0] max_q;
	logic                         ovf_q;
	logic                         fin_q;

	assign sqr_d = sample * sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			val_s1 <= ~sample_missing;
			last_s1 <= last_in_interval;
			smp_s1 <= sample;
			sqr_s1 <= sqr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
			sumsq_q <= '0;
			min_q <= ibs_pkg::SMP_MAX;
			max_q <= ibs_pkg::SMP_MIN;
			ovf_q <= 1'b0;
			fin_q <= 1'b0;
		end else if (clear) begin
			count_q <= '0;
			sum_q <= '0;
			sumsq_q <= '0;
			min_q <= ibs_pkg::SMP_MAX;
			max_q <= ibs_pkg::SMP_MIN;
			ovf_q <= 1'b0;
			fin_q <= 1'b0;
		end else if (vld_s1) begin
			if (val_s1) begin
				if (count_q >= ibs_pkg::MAX_BINS) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
					sum_q <= sum_q + {{(ibs_pkg::SUM_W-ibs_pkg::SAMPLE_W){smp_s1[15]}}, smp_s1};
					sumsq_q <= sumsq_q + {{(ibs_pkg::SQSUM_W-32){1'b0}}, sqr_s1};
					if (smp_s1 < $signed(min_q)) min_q <= smp_s1;
					if (smp_s1 > $signed(max_q)) max_q <= smp_s1;
				end
			end
			if (last_s1) fin_q <= 1'b1;
		end
	end

	assign acc = '{count: count_q, sum: sum_q, sumsq: sumsq_q,
		min_v: min_q, max_v: max_q, ovf: ovf_q};
	assign fin = fin_q;
	// hold off new requests until the interval end is handed over
	assign pend = (vld_s1 && last_s1) || fin_q;

endmodule

// ----- rtl/ibs_seq.sv -----
// Interval-end sequencer: mean division, n*sumsq, sum^2, n*(n-1), the
// variance division and the square root, all on one shared adder.
// Depends on ibs_pkg and ibs_addsub.
module ibs_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ibs_pkg::acc_t acc,
	input  logic          en,
	input  logic          res_free,
	output logic          idle,
	output logic          clear,
	output logic          res_load,
	output ibs_pkg::res_t res
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ABS  = 4'd1;
	localparam logic [3:0] ST_MDIV = 4'd2;
	localparam logic [3:0] ST_SQ   = 4'd3;
	localparam logic [3:0] ST_NUM  = 4'd4;
	localparam logic [3:0] ST_DIFF = 4'd5;
	localparam logic [3:0] ST_NM1  = 4'd6;
	localparam logic [3:0] ST_DEN  = 4'd7;
	localparam logic [3:0] ST_QDIV = 4'd8;
	localparam logic [3:0] ST_SQRT = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	localparam logic [5:0] LAST_32 = 6'd31;
	localparam logic [5:0] LAST_17 = 6'd16;
	localparam logic [5:0] LAST_64 = 6'd63;

	logic [3:0] state_q;
	logic [5:0] cnt_q;

	logic [ibs_pkg::COUNT_W-1:0]  n_q;
	logic [ibs_pkg::SUM_W-1:0]    sum_q;
	logic [ibs_pkg::SQSUM_W-1:0]  sumsq_q;
	logic [ibs_pkg::SAMPLE_W-1:0] min_q;
	logic [ibs_pkg::SAMPLE_W-1:0] max_q;
	logic                         ovf_q;
	logic                         en_q;

	logic [31:0]                 abs_q;
	logic [31:0]                 mq_q;
	logic [ibs_pkg::COUNT_W-1:0] mr_q;
	logic [63:0]                 sq_q;
	logic [63:0]                 num_q;
	logic [ibs_pkg::COUNT_W-1:0] nm1_q;
	logic [31:0]                 den_q;
	logic [31:0]                 dr_q;
	logic [33:0]                 sr_q;
	logic [31:0]                 root_q;

	logic [63:0] op_a;
	logic [63:0] op_b;
	logic        op_sub;
	logic [63:0] u_res;
	logic        u_carry;
	logic [4:0]  nbit;
	logic        has_dev;
	logic [15:0] mean_v;

	ibs_addsub u_addsub (
		.a     (op_a),
		.b     (op_b),
		.sub   (op_sub),
		.res   (u_res),
		.carry (u_carry)
	);

	// multiplier bit of n or n-1, walked from the top
	assign nbit = 5'd16 - cnt_q[4:0];

	always_comb begin
		op_a = '0;
		op_b = '0;
		op_sub = 1'b0;
		case (state_q)
			ST_ABS: begin
				op_b = {{32{sum_q[31]}}, sum_q};
				op_sub = 1'b1;
			end
			ST_MDIV: begin
				op_a = {46'b0, mr_q, mq_q[31]};
				op_b = {47'b0, n_q};
				op_sub = 1'b1;
			end
			ST_SQ: begin
				op_a = {sq_q[62:0], 1'b0};
				op_b = abs_q[~cnt_q[4:0]] ? {32'b0, abs_q} : 64'b0;
			end
			ST_NUM: begin
				op_a = {num_q[62:0], 1'b0};
				op_b = n_q[nbit] ? {16'b0, sumsq_q} : 64'b0;
			end
			ST_DIFF: begin
				op_a = num_q;
				op_b = sq_q;
				op_sub = 1'b1;
			end
			ST_NM1: begin
				op_a = {47'b0, n_q};
				op_b = 64'd1;
				op_sub = 1'b1;
			end
			ST_DEN: begin
				op_a = {32'b0, den_q[30:0], 1'b0};
				op_b = nm1_q[nbit] ? {47'b0, n_q} : 64'b0;
			end
			ST_QDIV: begin
				op_a = {31'b0, dr_q, num_q[63]};
				op_b = {32'b0, den_q};
				op_sub = 1'b1;
			end
			ST_SQRT: begin
				op_a = {28'b0, sr_q, num_q[63:62]};
				op_b = {30'b0, root_q, 2'b01};
				op_sub = 1'b1;
			end
			default: begin
				op_sub = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_ABS;
					cnt_q <= '0;
				end
				ST_ABS: state_q <= ST_MDIV;
				ST_MDIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_32) begin
						cnt_q <= '0;
						state_q <= (en_q && n_q > 17'd1) ? ST_SQ : ST_DONE;
					end
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_32) begin
						cnt_q <= '0;
						state_q <= ST_NUM;
					end
				end
				ST_NUM: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_17) begin
						cnt_q <= '0;
						state_q <= ST_DIFF;
					end
				end
				// numerator not above sum^2: deviation stays zero
				ST_DIFF: state_q <= u_carry ? ST_NM1 : ST_DONE;
				ST_NM1: state_q <= ST_DEN;
				ST_DEN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_17) begin
						cnt_q <= '0;
						state_q <= ST_QDIV;
					end
				end
				ST_QDIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_64) begin
						cnt_q <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_32) begin
						cnt_q <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					n_q <= acc.count;
					sum_q <= acc.sum;
					sumsq_q <= acc.sumsq;
					min_q <= acc.min_v;
					max_q <= acc.max_v;
					ovf_q <= acc.ovf;
					en_q <= en;
				end
			end
			ST_ABS: begin
				abs_q <= sum_q[31] ? u_res[31:0] : sum_q;
				mq_q <= sum_q[31] ? u_res[31:0] : sum_q;
				mr_q <= '0;
				root_q <= '0;
			end
			ST_MDIV: begin
				mr_q <= u_carry ? u_res[16:0] : {mr_q[15:0], mq_q[31]};
				mq_q <= {mq_q[30:0], u_carry};
				sq_q <= '0;
			end
			ST_SQ: begin
				sq_q <= u_res;
				num_q <= '0;
			end
			ST_NUM: num_q <= u_res;
			ST_DIFF: num_q <= u_res;
			ST_NM1: begin
				nm1_q <= u_res[16:0];
				den_q <= '0;
			end
			ST_DEN: begin
				den_q <= u_res[31:0];
				dr_q <= '0;
			end
			ST_QDIV: begin
				dr_q <= u_carry ? u_res[31:0] : {dr_q[30:0], num_q[63]};
				num_q <= {num_q[62:0], u_carry};
				sr_q <= '0;
			end
			ST_SQRT: begin
				sr_q <= u_carry ? u_res[33:0] : {sr_q[31:0], num_q[63:62]};
				root_q <= {root_q[30:0], u_carry};
				num_q <= {num_q[61:0], 2'b00};
			end
			default: begin
				en_q <= en_q;
			end
		endcase
	end

	assign has_dev = en_q && (n_q > 17'd1);

	// truncated quotient back to signed, saturated to 16 bits
	always_comb begin
		if (n_q == '0) begin
			mean_v = '0;
		end else if (!sum_q[31]) begin
			mean_v = (|mq_q[31:15]) ? ibs_pkg::SMP_MAX : mq_q[15:0];
		end else if ((|mq_q[31:16]) || (mq_q[15] && (|mq_q[14:0]))) begin
			mean_v = ibs_pkg::SMP_MIN;
		end else begin
			mean_v = (~mq_q[15:0]) + 16'd1;
		end
	end

	always_comb begin
		res.count = n_q;
		res.has_values = (n_q != '0);
		res.total = res.has_values ? sum_q : '0;
		res.smallest = res.has_values ? min_q : '0;
		res.largest = res.has_values ? max_q : '0;
		res.mean = mean_v;
		res.deviation = has_dev ? ((|root_q[31:16]) ? 16'hFFFF : root_q[15:0]) : 16'd0;
		res.has_dev = has_dev;
		res.ovf = ovf_q;
	end

	assign idle = (state_q == ST_IDLE);
	assign clear = idle && start;
	assign res_load = (state_q == ST_DONE) && res_free;

endmodule

// ----- rtl/interval_bin_statistics_core.sv -----
// Interval bin statistics: count, sum, min, max, mean and unbiased deviation
// of the non-missing Q8.8 samples of one interval.
//
// Input channel (in_valid/in_ready) takes one bin sample per request, with a
// missing flag and a last-of-interval flag. Samples inside an interval are
// taken one per cycle. The request marked last closes the interval; the
// block then drops in_ready while it finishes the statistics on one shared
// 64-bit adder: a 32-step mean division and, with the deviation, a 32-step
// square, two 17-step products, a 64-step division and a 32-step square
// root. Its bound is that single adder.
// Output channel (out_valid/out_ready) carries one result per interval from
// an output register; a stalled receiver holds the result, and the next
// interval is taken meanwhile until its own result is ready to load.
// cfg_wr_en/cfg_wr_data write stddev_enable (reset 1), read at interval end.
// Reset clears the accumulators, the sequencer and the output valid.
// Depends on ibs_pkg, ibs_accum, ibs_seq.
module interval_bin_statistics_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample,
	input  logic               sample_missing,
	input  logic               last_in_interval,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [16:0]        value_count,
	output logic               has_values,
	output logic signed [31:0] total,
	output logic signed [15:0] smallest,
	output logic signed [15:0] largest,
	output logic signed [15:0] mean,
	output logic [15:0]        deviation,
	output logic               has_deviation,
	output logic               count_overflow
);

	logic          en_q;
	logic          in_fire;
	logic          clear;
	logic          fin;
	logic          pend;
	logic          idle;
	logic          res_free;
	logic          res_load;
	ibs_pkg::acc_t acc;
	ibs_pkg::res_t res;
	ibs_pkg::res_t out_q;
	logic          out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
		end else if (cfg_wr_en) begin
			en_q <= cfg_wr_data;
		end
	end

	assign in_ready = idle && !pend;
	assign in_fire = in_valid && in_ready;

	ibs_accum u_accum (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_fire          (in_fire),
		.sample           (sample),
		.sample_missing   (sample_missing),
		.last_in_interval (last_in_interval),
		.clear            (clear),
		.acc              (acc),
		.fin              (fin),
		.pend             (pend)
	);

	ibs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (fin),
		.acc      (acc),
		.en       (en_q),
		.res_free (res_free),
		.idle     (idle),
		.clear    (clear),
		.res_load (res_load),
		.res      (res)
	);

	assign res_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign value_count = out_q.count;
	assign has_values = out_q.has_values;
	assign total = out_q.total;
	assign smallest = out_q.smallest;
	assign largest = out_q.largest;
	assign mean = out_q.mean;
	assign deviation = out_q.deviation;
	assign has_deviation = out_q.has_dev;
	assign count_overflow = out_q.ovf;

endmodule

// ----- tb/interval_bin_statistics_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for interval_bin_statistics_core: streams bin samples, predicts each interval's
// statistics in-bench and checks every result in order. Depends on ibs_pkg and the RTL.
module interval_bin_statistics_core_tb;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic               cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] sample;
	logic               sample_missing;
	logic               last_in_interval;
	logic               out_valid;
	logic               out_ready;
	logic [16:0]        value_count;
	logic               has_values;
	logic signed [31:0] total;
	logic signed [15:0] smallest;
	logic signed [15:0] largest;
	logic signed [15:0] mean;
	logic [15:0]        deviation;
	logic               has_deviation;
	logic               count_overflow;

	interval_bin_statistics_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.sample_missing(sample_missing),
		.last_in_interval(last_in_interval),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value_count(value_count),
		.has_values(has_values),
		.total(total),
		.smallest(smallest),
		.largest(largest),
		.mean(mean),
		.deviation(deviation),
		.has_deviation(has_deviation),
		.count_overflow(count_overflow)
	);

	// running interval state of the predictor
	int                 bin_count;
	bit [31:0]          run_sum;
	bit [47:0]          run_sumsq;
	logic signed [15:0] run_min;
	logic signed [15:0] run_max;
	bit                 run_ovf;
	bit                 dev_enable;

	ibs_pkg::res_t pending_stats[$];
	int            err_cnt;
	bit            no_idle;
	int            hold_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(30_000_000);
		$display("Test completed with failures");
		$finish;
	end

	function automatic bit [63:0] floor_sqrt(input bit [63:0] x);
		bit [63:0] root;
		bit [63:0] trial;
		root = '0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= x) root = trial;
		end
		return root;
	endfunction

	task automatic clear_bins();
		bin_count = 0;
		run_sum   = '0;
		run_sumsq = '0;
		run_min   = ibs_pkg::SMP_MAX;
		run_max   = ibs_pkg::SMP_MIN;
		run_ovf   = 1'b0;
	endtask

	task automatic fold_bin(input logic signed [15:0] value, input logic missing,
			input logic last);
		ibs_pkg::res_t want;
		longint        v;
		longint        signed_sum;
		longint        avg;
		bit [63:0]     n;
		bit [63:0]     mag;
		bit [63:0]     num;
		bit [63:0]     sq;
		bit [63:0]     den;
		bit [63:0]     dev;
		v = value;
		if (!missing) begin
			if (bin_count >= int'(ibs_pkg::MAX_BINS)) begin
				run_ovf = 1'b1;
			end else begin
				bin_count++;
				run_sum   = run_sum + 32'(v);
				run_sumsq = run_sumsq + 48'(v * v);
				if (value < run_min) run_min = value;
				if (value > run_max) run_max = value;
			end
		end
		if (!last) return;
		want            = '0;
		want.count      = 17'(bin_count);
		want.has_values = bin_count > 0;
		want.has_dev    = dev_enable && bin_count > 1;
		want.ovf        = run_ovf;
		signed_sum      = longint'($signed(run_sum));
		if (bin_count > 0) begin
			avg = signed_sum / bin_count;
			if (avg > 32767) avg = 32767;
			if (avg < -32768) avg = -32768;
			want.total    = run_sum;
			want.smallest = run_min;
			want.largest  = run_max;
			want.mean     = avg[15:0];
		end
		if (want.has_dev) begin
			n   = 64'(bin_count);
			mag = signed_sum < 0 ? -signed_sum : signed_sum;
			num = n * 64'(run_sumsq);
			sq  = mag * mag;
			den = n * (n - 1);
			dev = '0;
			// a wrapped sum can leave the numerator negative: deviation stays 0
			if (num > sq && den != 0) dev = floor_sqrt((num - sq) / den);
			if (dev > 64'd65535) dev = 64'd65535;
			want.deviation = dev[15:0];
		end
		pending_stats.push_back(want);
		clear_bins();
	endtask

	task automatic check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			err_cnt++;
		end
	endtask

	task automatic check_result();
		ibs_pkg::res_t want;
		if (pending_stats.size() == 0) begin
			$error("result arrived with no interval outstanding");
			err_cnt++;
			return;
		end
		want = pending_stats.pop_front();
		check_field("value_count", want.count, value_count);
		check_field("has_values", want.has_values, has_values);
		check_field("total", $signed(want.total), total);
		check_field("smallest", $signed(want.smallest), smallest);
		check_field("largest", $signed(want.largest), largest);
		check_field("mean", $signed(want.mean), mean);
		check_field("deviation", want.deviation, deviation);
		check_field("has_deviation", want.has_dev, has_deviation);
		check_field("count_overflow", want.ovf, count_overflow);
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			fold_bin(sample, sample_missing, last_in_interval);
		if (arst_n && out_valid && out_ready)
			check_result();
	end

	// result receiver: random stalls per result, plus long hold-offs on request
	initial begin : result_sink
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready = 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			gap = no_idle ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid && hold_cycles == 0);
		end
	end

	// call at a falling edge; returns at the falling edge after the request is taken
	task automatic send_bin(input logic signed [15:0] value, input logic missing,
			input logic last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid         = 1'b1;
		sample           = value;
		sample_missing   = missing;
		last_in_interval = last;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return 16'($urandom);
		if (r < 6) begin
			case ($urandom_range(0, 4))
				0: return 16'sh7FFF;
				1: return 16'sh8000;
				2: return 16'sh0000;
				3: return 16'shFFFF;
				default: return 16'sh0001;
			endcase
		end
		return 16'(int'($urandom_range(0, 1023)) - 512);
	endfunction

	task automatic send_interval(input int len, input int miss_pct);
		for (int i = 0; i < len; i++)
			send_bin(pick_value(), $urandom_range(0, 99) < miss_pct, i == len - 1);
	endtask

	// drain all results, then let the sequencer finish before touching config
	task automatic settle();
		in_valid = 1'b0;
		while (pending_stats.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_enable(input logic value);
		settle();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		dev_enable  = value;
	endtask

	task automatic test_directed();
		// empty interval
		send_bin(16'sh1234, 1'b1, 1'b1);
		// single value: no deviation
		send_bin(16'sh7FFF, 1'b0, 1'b1);
		send_bin(16'sh8000, 1'b0, 1'b0);
		send_bin(16'sh7FFF, 1'b0, 1'b1);
		// missing bins inside, last one missing
		send_bin(16'shFFFF, 1'b1, 1'b0);
		send_bin(16'sh0000, 1'b0, 1'b0);
		send_bin(16'sh0001, 1'b0, 1'b0);
		send_bin(16'sh0100, 1'b0, 1'b0);
		send_bin(16'sh8000, 1'b1, 1'b1);
		// constant values give zero spread
		send_bin(16'sh8000, 1'b0, 1'b0);
		send_bin(16'sh8000, 1'b0, 1'b0);
		send_bin(16'sh8000, 1'b0, 1'b1);
		send_bin(16'sh0064, 1'b0, 1'b0);
		send_bin(16'shFED4, 1'b0, 1'b0);
		send_bin(16'sh0007, 1'b0, 1'b0);
		send_bin(16'sh5555, 1'b0, 1'b0);
		send_bin(16'shAAAA, 1'b0, 1'b1);
		send_bin(16'sh7FFF, 1'b1, 1'b0);
		send_bin(16'sh0000, 1'b1, 1'b0);
		send_bin(16'sh0005, 1'b0, 1'b1);
		settle();
	endtask

	task automatic test_stddev_enable();
		for (int pass = 0; pass < 2; pass++) begin
			write_enable(pass == 0 ? 1'b0 : 1'b1);
			send_bin(16'sh0300, 1'b0, 1'b1);
			send_bin(16'sh8000, 1'b0, 1'b0);
			send_bin(16'sh7FFF, 1'b0, 1'b1);
			repeat (4) send_interval($urandom_range(2, 12), 20);
		end
		settle();
	endtask

	task automatic test_output_stall();
		no_idle     = 1'b1;
		hold_cycles = 1500;
		repeat (6) send_interval(3, 0);
		no_idle = 1'b0;
		settle();
	endtask

	task automatic test_random_intervals();
		int sent;
		int len;
		int miss_pct;
		int r;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_enable(1'b0);
				5: write_enable(1'b1);
				default: write_enable(1'($urandom_range(0, 1)));
			endcase
			no_idle = (phase == 3);
			sent = 0;
			while (sent < 280) begin
				r = $urandom_range(0, 99);
				if (r < 70) len = $urandom_range(1, 12);
				else if (r < 95) len = $urandom_range(13, 60);
				else len = $urandom_range(61, 200);
				r = $urandom_range(0, 9);
				miss_pct = r < 5 ? 0 : (r < 9 ? 25 : 100);
				send_interval(len, miss_pct);
				sent += len;
			end
		end
		no_idle = 1'b0;
		settle();
	endtask

	initial begin
		err_cnt          = 0;
		no_idle          = 1'b0;
		hold_cycles      = 0;
		dev_enable       = 1'b1;
		clear_bins();
		in_valid         = 1'b0;
		sample           = '0;
		sample_missing   = 1'b0;
		last_in_interval = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_wr_data      = 1'b0;
		arst_n           = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_stddev_enable();
		test_output_stall();
		test_random_intervals();

		settle();
		if (err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
